>>> rtl/core/lms_adaptive_noise_canceller_unit_macros.svh
// Assertion macros shared by the LMS noise canceller RTL.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef LMS_ADAPTIVE_NOISE_CANCELLER_UNIT_MACROS_SVH
`define LMS_ADAPTIVE_NOISE_CANCELLER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LMS_ANC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMS_ANC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lms_anc_pkg.sv
// Shared types and constants of the LMS noise canceller.
// No dependencies; used by interfaces, ctrl, datapath, top.
package lms_anc_pkg;

  localparam int unsigned TapsDefault = 128;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned ProdW       = WeightW + SampleW;
  localparam int unsigned AccW        = 64;
  localparam int unsigned FracBits    = 24;
  localparam int unsigned ShiftW      = 6;
  localparam logic [ShiftW-1:0] ShiftReset = 6'd16;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StFilt,
    StFiltDrain,
    StErr,
    StUpd,
    StUpdDrain
  } ctrl_state_e;

  typedef struct packed {
    logic clr;
    logic accept;
    logic issue;
    logic upd;
    logic rewind;
    logic err_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic pipe_empty;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/core/lms_anc_if.sv
// Valid/ready channels of the LMS noise canceller.
// Depends on lms_anc_pkg for the sample width.
interface lms_anc_in_if;
  import lms_anc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] reference_sample;
  logic signed [SampleW-1:0] primary_sample;
  modport source (output valid, reference_sample, primary_sample, input ready);
  modport sink (input valid, reference_sample, primary_sample, output ready);
endinterface

interface lms_anc_out_if;
  import lms_anc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] error_sample;
  modport source (output valid, error_sample, input ready);
  modport sink (input valid, error_sample, output ready);
endinterface

>>> rtl/core/lms_anc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lms_anc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/lms_anc_ctrl.sv
// Sequencer of the LMS noise canceller: clear, filter, error, update passes.
// Depends on lms_anc_pkg and the assertion macro header.
`include "lms_adaptive_noise_canceller_unit_macros.svh"

module lms_anc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  lms_anc_pkg::ctrl_sts_t sts_i,
  output lms_anc_pkg::ctrl_cmd_t cmd_o
);
  import lms_anc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (sts_i.last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) state_d = StFilt;
      end
      StFilt: begin
        if (sts_i.last) state_d = StFiltDrain;
      end
      StFiltDrain: begin
        if (sts_i.pipe_empty) state_d = StErr;
      end
      StErr: begin
        if (sts_i.out_free) state_d = StUpd;
      end
      StUpd: begin
        if (sts_i.last) state_d = StUpdDrain;
      end
      StUpdDrain: begin
        if (sts_i.pipe_empty) state_d = StIdle;
      end
      default: state_d = StClear;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
      end
      StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      StFilt: begin
        cmd_o.issue = 1'b1;
      end
      StErr: begin
        cmd_o.err_load = sts_i.out_free;
        cmd_o.rewind   = sts_i.out_free;
      end
      StUpd: begin
        cmd_o.issue = 1'b1;
        cmd_o.upd   = 1'b1;
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  `LMS_ANC_ASSERT_NXT(a_accept_starts_filter, in_valid_i && in_ready_o, state_q == StFilt, "accepted word did not start a filter pass")
  `LMS_ANC_ASSERT_IMP(a_err_after_drain, cmd_o.err_load, sts_i.pipe_empty && sts_i.out_free, "error loaded with pipeline busy or output full")
  `LMS_ANC_ASSERT_IMP(a_idle_quiet, state_q == StIdle, sts_i.pipe_empty, "pipeline busy while idle")

endmodule

>>> rtl/core/lms_anc_datapath.sv
// Datapath of the LMS noise canceller: tap and weight RAMs, shared multiplier,
// accumulator, error saturation, weight update and output register.
// Depends on lms_anc_pkg, lms_anc_ram and the assertion macro header.
`include "lms_adaptive_noise_canceller_unit_macros.svh"

module lms_anc_datapath #(
  parameter int unsigned Taps = lms_anc_pkg::TapsDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  lms_anc_pkg::ctrl_cmd_t                   cmd_i,
  output lms_anc_pkg::ctrl_sts_t                   sts_o,
  input  logic                                     cfg_we_i,
  input  logic        [lms_anc_pkg::ShiftW-1:0]    cfg_wdata_i,
  input  logic signed [lms_anc_pkg::SampleW-1:0]   reference_sample_i,
  input  logic signed [lms_anc_pkg::SampleW-1:0]   primary_sample_i,
  input  logic                                     rsp_ready_i,
  output logic                                     rsp_valid_o,
  output logic signed [lms_anc_pkg::SampleW-1:0]   error_sample_o
);
  import lms_anc_pkg::*;

  localparam int unsigned IdxW = $clog2(Taps);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Taps - 1);

  logic [ShiftW-1:0]         shift_q;
  logic [IdxW-1:0]           cnt_q, cnt_d;
  logic [IdxW-1:0]           taddr_q, taddr_d;
  logic [IdxW-1:0]           ptr_q, ptr_d;
  logic signed [SampleW-1:0] prim_q;
  logic signed [SampleW-1:0] err_q;
  logic signed [AccW-1:0]    acc_q;
  logic                      v1_q, v2_q;
  logic                      mode1_q, mode2_q;
  logic [IdxW-1:0]           idx1_q, idx2_q;
  logic signed [ProdW-1:0]   prod_q, prod_d;
  logic signed [WeightW-1:0] w2_q;
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_data_q;

  logic [WeightW-1:0]        w_rd;
  logic [SampleW-1:0]        t_rd;
  logic signed [WeightW-1:0] mul_a;
  logic                      w_we, t_we;
  logic [IdxW-1:0]           w_waddr, t_waddr;
  logic [WeightW-1:0]        w_wdata;
  logic [SampleW-1:0]        t_wdata;

  logic signed [AccW-1:0]    y_full;
  logic signed [AccW-1:0]    diff;
  logic signed [SampleW-1:0] err_sat;
  logic signed [ProdW-1:0]   delta;
  logic signed [ProdW:0]     nw;
  logic signed [WeightW-1:0] w_sat;
  logic                      out_free;

  lms_anc_ram #(.Width(WeightW), .Depth(Taps)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q),
    .rdata_o (w_rd)
  );

  lms_anc_ram #(.Width(SampleW), .Depth(Taps)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .re_i    (cmd_i.issue),
    .raddr_i (taddr_q),
    .rdata_o (t_rd)
  );

  // pointer to the newest tap; older taps follow at rising addresses
  assign ptr_d = (ptr_q == '0) ? LastIdx : ptr_q - IdxW'(1);

  always_comb begin
    cnt_d   = cnt_q;
    taddr_d = taddr_q;
    if (cmd_i.accept) begin
      cnt_d   = '0;
      taddr_d = ptr_d;
    end else if (cmd_i.rewind) begin
      cnt_d   = '0;
      taddr_d = ptr_q;
    end else if (cmd_i.clr || cmd_i.issue) begin
      cnt_d   = (cnt_q == LastIdx) ? '0 : cnt_q + IdxW'(1);
      taddr_d = (taddr_q == LastIdx) ? '0 : taddr_q + IdxW'(1);
    end
  end

  assign mul_a  = mode1_q ? WeightW'(err_q) : $signed(w_rd);
  assign prod_d = ProdW'(mul_a) * ProdW'($signed(t_rd));

  assign y_full  = acc_q >>> FracBits;
  assign diff    = AccW'(prim_q) - y_full;
  assign err_sat = ((&diff[AccW-1:SampleW-1]) || !(|diff[AccW-1:SampleW-1])) ?
                   diff[SampleW-1:0] :
                   (diff[AccW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}});

  assign delta = prod_q >>> shift_q;
  assign nw    = (ProdW+1)'(w2_q) + (ProdW+1)'(delta);
  assign w_sat = ((&nw[ProdW:WeightW-1]) || !(|nw[ProdW:WeightW-1])) ?
                 nw[WeightW-1:0] :
                 (nw[ProdW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}});

  always_comb begin
    w_we    = 1'b0;
    w_waddr = idx2_q;
    w_wdata = w_sat;
    if (cmd_i.clr) begin
      w_we    = 1'b1;
      w_waddr = cnt_q;
      w_wdata = '0;
    end else if (v2_q && mode2_q) begin
      w_we = 1'b1;
    end
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = ptr_d;
    t_wdata = reference_sample_i;
    if (cmd_i.clr) begin
      t_we    = 1'b1;
      t_waddr = cnt_q;
      t_wdata = '0;
    end else if (cmd_i.accept) begin
      t_we = 1'b1;
    end
  end

  assign out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= ShiftReset;
      cnt_q       <= '0;
      taddr_q     <= '0;
      ptr_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) shift_q <= cfg_wdata_i;
      cnt_q       <= cnt_d;
      taddr_q     <= taddr_d;
      if (cmd_i.accept) ptr_q <= ptr_d;
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      out_valid_q <= cmd_i.err_load || (out_valid_q && !rsp_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    mode1_q <= cmd_i.upd;
    idx1_q  <= cnt_q;
    mode2_q <= mode1_q;
    idx2_q  <= idx1_q;
    prod_q  <= prod_d;
    w2_q    <= $signed(w_rd);
    if (cmd_i.accept) begin
      prim_q <= primary_sample_i;
      acc_q  <= '0;
    end else if (v2_q && !mode2_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.err_load) begin
      err_q      <= err_sat;
      out_data_q <= err_sat;
    end
  end

  assign sts_o.last       = (cnt_q == LastIdx);
  assign sts_o.pipe_empty = !v1_q && !v2_q;
  assign sts_o.out_free   = out_free;

  assign rsp_valid_o    = out_valid_q;
  assign error_sample_o = out_data_q;

  `LMS_ANC_ASSERT_NXT(a_stage2_follows, v1_q, v2_q, "stage two lost a product")
  `LMS_ANC_ASSERT_NXT(a_err_to_out, cmd_i.err_load, rsp_valid_o, "error word not presented")
  `LMS_ANC_ASSERT_IMP(a_clr_quiet, cmd_i.clr, !v1_q && !v2_q && !cmd_i.accept, "clear overlaps a pass")
  `LMS_ANC_ASSERT_IMP(a_ptr_range, cmd_i.accept, ptr_q <= LastIdx, "tap pointer out of range")

endmodule

>>> rtl/core/lms_adaptive_noise_canceller_unit.sv
// LMS adaptive noise canceller, top level.
// Depends on lms_anc_pkg, lms_anc_if, lms_anc_ctrl and lms_anc_datapath.
//
// Each word on req_i carries a reference-noise sample and a primary sample;
// each yields one error word on rsp_o, primary minus the FIR estimate,
// saturated to 16 bits, after which all Taps Q8.24 weights take an LMS step
// scaled by 2^-update_shift (cfg_wdata_i, reset 16). A filter pass and an
// update pass each stream one tap per cycle through the single shared
// multiplier and the one read port of the tap and weight RAMs. After reset
// a clearing pass zeroes both RAMs before the first word is accepted. The
// finished error word sits in an output register, so the update pass
// proceeds while it waits to be taken.
module lms_adaptive_noise_canceller_unit #(
  parameter int unsigned Taps = lms_anc_pkg::TapsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lms_anc_pkg::ShiftW-1:0]  cfg_wdata_i,
  lms_anc_in_if.sink                      req_i,
  lms_anc_out_if.source                   rsp_o
);
  import lms_anc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lms_anc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lms_anc_datapath #(.Taps(Taps)) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .reference_sample_i (req_i.reference_sample),
    .primary_sample_i   (req_i.primary_sample),
    .rsp_ready_i        (rsp_o.ready),
    .rsp_valid_o        (rsp_o.valid),
    .error_sample_o     (rsp_o.error_sample)
  );

endmodule
